// ===== rtl/icfr_pkg.sv =====
package icfr_pkg;

  // Request kinds on the input channel.
  localparam logic [1:0] ReqRxByte = 2'd0;
  localparam logic [1:0] ReqTick   = 2'd1;
  localparam logic [1:0] ReqSend   = 2'd2;

  // Message codes that the endpoint reacts to.
  localparam logic [5:0] CodeOpenDoor        = 6'd16;
  localparam logic [5:0] CodeCallSecondary   = 6'd19;
  localparam logic [5:0] CodeCallEntry       = 6'd48;
  localparam logic [5:0] CodeCallEntryScreen = 6'd50;

  // Configuration register indexes.
  localparam logic [1:0] CfgOwnAddress  = 2'd0;
  localparam logic [1:0] CfgReopenWin   = 2'd1;
  localparam logic [1:0] CfgOpenDelay   = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [7:0]  OwnAddressRst = 8'd12;
  localparam logic [15:0] ReopenWinRst  = 16'd60000;
  localparam logic [15:0] OpenDelayRst  = 16'd2500;

  localparam logic [15:0] MsSatValue = 16'hFFFF;

  typedef enum logic [1:0] {
    EvNone       = 2'd0,
    EvRing       = 2'd1,
    EvRingNotice = 2'd2,
    EvTx         = 2'd3
  } ev_e;

  // One queued result record: either a single frame report or a
  // three-byte transmission that the output side walks through.
  typedef struct packed {
    ev_e        ev;
    logic [5:0] code;
    logic [7:0] addr;
    logic       is_frame;
  } rec_t;

  // Number of set bits in a byte.
  function automatic logic [3:0] pop8(input logic [7:0] v);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < 8; i++) begin
      n = n + {3'd0, v[i]};
    end
    return n;
  endfunction

endpackage

// ===== rtl/intercom_frame_receiver_autoopen.sv =====
// A result is written into the result queue when its request is accepted and is offered
// from there. One request per cycle while the queue is not full; a transmission holds the
// output port for its three bytes, one byte per output transfer, before the next record.
// A two-entry result queue lets requests be accepted while a result waits to be taken.
// Reset: configuration returns to address 12, window 60000 ms and delay 2500 ms;
// the frame assembler, opening timer, delay timer and result queue are cleared.
module intercom_frame_receiver_autoopen
  import icfr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Request channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [5:0]  local_code_i,
  // Result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  event_res_o,
  output logic [5:0]  frame_code_o,
  output logic [7:0]  frame_address_o,
  output logic [7:0]  tx_byte_o,
  output logic        last_o,
  // Configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  // Configuration registers.
  logic [7:0]  own_address_q;
  logic [15:0] reopen_window_q;
  logic [15:0] open_delay_q;

  // Endpoint state.
  logic [1:0]  byte_pos_q, byte_pos_d;
  logic [7:0]  first_byte_q, first_byte_d;
  logic [7:0]  second_byte_q, second_byte_d;
  logic        opened_q, opened_d;
  logic [15:0] ms_since_open_q, ms_since_open_d;
  logic        delay_pending_q, delay_pending_d;
  logic [15:0] delay_remaining_q, delay_remaining_d;

  // Result queue.
  rec_t        rec_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q;
  logic [1:0]  idx_q;

  logic        in_fire;
  logic        out_fire;
  logic        pop;
  logic        push;
  rec_t        push_rec;
  rec_t        head;

  // Frame decode of the third byte.
  logic [5:0]  rx_code;
  logic [7:0]  rx_addr;
  logic [3:0]  rx_sum;
  logic        rx_ok;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (cnt_q == 2'd2);
  assign in_fire     = in_valid_i && !in_stall_o;

  assign rx_code = {second_byte_q[3:0], first_byte_q[7:6]};
  assign rx_addr = {rx_byte_i[3:0], second_byte_q[7:4]};
  assign rx_sum  = pop8({2'b00, rx_code}) + pop8(rx_addr);
  assign rx_ok   = (rx_code != 6'd0) && (rx_sum == rx_byte_i[7:4]);

  // Request processing: state update and the record to queue, if any.
  always_comb begin
    byte_pos_d        = byte_pos_q;
    first_byte_d      = first_byte_q;
    second_byte_d     = second_byte_q;
    opened_d          = opened_q;
    ms_since_open_d   = ms_since_open_q;
    delay_pending_d   = delay_pending_q;
    delay_remaining_d = delay_remaining_q;
    push              = 1'b0;
    push_rec          = '{ev: EvNone, code: rx_code, addr: rx_addr, is_frame: 1'b0};

    unique case (req_type_i)
      ReqRxByte: begin
        if (byte_pos_q == 2'd0) begin
          first_byte_d = rx_byte_i;
          byte_pos_d   = 2'd1;
        end else if (byte_pos_q == 2'd1) begin
          second_byte_d = rx_byte_i;
          byte_pos_d    = 2'd2;
        end else begin
          byte_pos_d = 2'd0;
          if (rx_ok) begin
            push = 1'b1;
            if (rx_addr == own_address_q) begin
              if (rx_code == CodeCallSecondary || rx_code == CodeCallEntry) begin
                push_rec.ev = EvRing;
              end else if (rx_code == CodeCallEntryScreen) begin
                if (opened_q && (ms_since_open_q < reopen_window_q)) begin
                  delay_pending_d   = 1'b1;
                  delay_remaining_d = open_delay_q;
                end else begin
                  push_rec.ev = EvRingNotice;
                end
              end else if (rx_code == CodeOpenDoor) begin
                opened_d        = 1'b1;
                ms_since_open_d = 16'd0;
              end
            end
          end
        end
      end
      ReqTick: begin
        if (opened_q && (ms_since_open_q != MsSatValue)) begin
          ms_since_open_d = ms_since_open_q + 16'd1;
        end
        if (delay_pending_q) begin
          if (delay_remaining_q <= 16'd1) begin
            delay_pending_d   = 1'b0;
            delay_remaining_d = 16'd0;
            push              = 1'b1;
            push_rec          = '{ev: EvTx, code: CodeOpenDoor, addr: own_address_q,
                                  is_frame: 1'b1};
          end else begin
            delay_remaining_d = delay_remaining_q - 16'd1;
          end
        end
      end
      ReqSend: begin
        if (local_code_i != 6'd0) begin
          push     = 1'b1;
          push_rec = '{ev: EvTx, code: local_code_i, addr: own_address_q, is_frame: 1'b1};
          if (local_code_i == CodeOpenDoor) begin
            opened_d        = 1'b1;
            ms_since_open_d = 16'd0;
          end
        end
      end
      default: begin
        // Unknown request kind: nothing happens.
      end
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_address_q   <= OwnAddressRst;
      reopen_window_q <= ReopenWinRst;
      open_delay_q    <= OpenDelayRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgOwnAddress: own_address_q   <= cfg_data_i[7:0];
        CfgReopenWin:  reopen_window_q <= cfg_data_i;
        CfgOpenDelay:  open_delay_q    <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Endpoint state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_pos_q        <= 2'd0;
      first_byte_q      <= 8'd0;
      second_byte_q     <= 8'd0;
      opened_q          <= 1'b0;
      ms_since_open_q   <= 16'd0;
      delay_pending_q   <= 1'b0;
      delay_remaining_q <= 16'd0;
    end else if (in_fire) begin
      byte_pos_q        <= byte_pos_d;
      first_byte_q      <= first_byte_d;
      second_byte_q     <= second_byte_d;
      opened_q          <= opened_d;
      ms_since_open_q   <= ms_since_open_d;
      delay_pending_q   <= delay_pending_d;
      delay_remaining_q <= delay_remaining_d;
    end
  end

  // Output side: the head record, walked byte by byte for a transmission.
  assign head        = rec_q[rd_ptr_q];
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_fire    = out_valid_o && !out_stall_i;
  assign last_o      = !head.is_frame || (idx_q == 2'd2);
  assign pop         = out_fire && last_o;

  assign event_res_o     = head.ev;
  assign frame_code_o    = head.code;
  assign frame_address_o = head.addr;

  always_comb begin
    logic [3:0] sum;
    sum = pop8({2'b00, head.code}) + pop8(head.addr);
    if (!head.is_frame) begin
      tx_byte_o = 8'd0;
    end else begin
      unique case (idx_q)
        2'd0:    tx_byte_o = {head.code[1:0], 6'd0};
        2'd1:    tx_byte_o = {head.addr[3:0], head.code[5:2]};
        default: tx_byte_o = {sum, head.addr[7:4]};
      endcase
    end
  end

  // Queue payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (in_fire && push) begin
      rec_q[wr_ptr_q] <= push_rec;
    end
  end

  // Queue pointers, fill count and byte index.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
      idx_q    <= 2'd0;
    end else begin
      if (in_fire && push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
        idx_q    <= 2'd0;
      end else if (out_fire) begin
        idx_q <= idx_q + 2'd1;
      end
      cnt_q <= cnt_q + {1'b0, (in_fire && push)} - {1'b0, pop};
    end
  end

  // The queue never holds more than two records.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("result queue overflow");

  // Requests are only held back while results are waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_stall_o |-> out_valid_o)
    else $error("request stalled with an empty result queue");

  // A non-zero byte index only occurs while a transmission is at the head.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (idx_q != 2'd0) |-> (out_valid_o && head.is_frame))
    else $error("byte index set without a transmission at the head");

  // Fill count and pointers agree.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (cnt_q == 2'd1) |-> (wr_ptr_q != rd_ptr_q))
    else $error("queue pointers inconsistent with fill count");

endmodule

// ===== tb/sv/intercom_frame_receiver_autoopen_test.sv =====
`timescale 1ns / 100ps

module intercom_frame_receiver_autoopen_test;
  import icfr_pkg::*;

  // The one request kind that the endpoint has no use for.
  localparam logic [1:0] ReqUnused = 2'd3;
  localparam int CycleLimit = 200000;
  localparam int SettleCycles = 8;

  // One report or transmit byte as the endpoint should present it.
  typedef struct packed {
    ev_e        ev;
    logic [5:0] code;
    logic [7:0] addr;
    logic [7:0] tx;
    logic       last;
  } report_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  req_type_i;
  logic [7:0]  rx_byte_i;
  logic [5:0]  local_code_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  event_res_o;
  logic [5:0]  frame_code_o;
  logic [7:0]  frame_address_o;
  logic [7:0]  tx_byte_o;
  logic        last_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [15:0] cfg_data_i;

  // Reports still owed by the endpoint, oldest first.
  report_t due_reports[$];
  int      errors;
  int      cycle_count;
  bit      src_idle;
  bit      sink_idle;
  int      sink_hold;

  // Mirror of the endpoint's registers and state.
  logic [7:0]  m_own;
  logic [15:0] m_window;
  logic [15:0] m_delay;
  logic [1:0]  m_pos;
  logic [7:0]  m_b0;
  logic [7:0]  m_b1;
  logic        m_opened;
  logic [15:0] m_ms_open;
  logic        m_pending;
  logic [15:0] m_remaining;

  intercom_frame_receiver_autoopen u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .rx_byte_i      (rx_byte_i),
    .local_code_i   (local_code_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .event_res_o    (event_res_o),
    .frame_code_o   (frame_code_o),
    .frame_address_o(frame_address_o),
    .tx_byte_o      (tx_byte_o),
    .last_o         (last_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Give up if the run hangs.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("** intercom_frame_receiver_autoopen: FAILED **");
      $finish;
    end
  end

  function automatic void clear_mirror();
    m_own       = OwnAddressRst;
    m_window    = ReopenWinRst;
    m_delay     = OpenDelayRst;
    m_pos       = 2'd0;
    m_b0        = 8'd0;
    m_b1        = 8'd0;
    m_opened    = 1'b0;
    m_ms_open   = 16'd0;
    m_pending   = 1'b0;
    m_remaining = 16'd0;
  endfunction

  // The three bus bytes of a transmitted frame; the last one closes the request.
  function automatic void owe_tx_frame(input logic [5:0] code, input logic [7:0] addr);
    int s;
    s = $countones(code) + $countones(addr);
    due_reports.push_back('{EvTx, code, addr, {code[1:0], 6'd0}, 1'b0});
    due_reports.push_back('{EvTx, code, addr, {addr[3:0], code[5:2]}, 1'b0});
    due_reports.push_back('{EvTx, code, addr, {s[3:0], addr[7:4]}, 1'b1});
  endfunction

  // Work out what one accepted request makes the endpoint report.
  function automatic void react_to_request(input logic [1:0] kind, input logic [7:0] rxb,
                                           input logic [5:0] lc);
    logic [5:0] code;
    logic [7:0] addr;
    int         s;
    ev_e        ev;
    case (kind)
      ReqRxByte: begin
        if (m_pos == 2'd0) begin
          m_b0  = rxb;
          m_pos = 2'd1;
        end else if (m_pos == 2'd1) begin
          m_b1  = rxb;
          m_pos = 2'd2;
        end else begin
          code  = {m_b1[3:0], m_b0[7:6]};
          addr  = {rxb[3:0], m_b1[7:4]};
          s     = $countones(code) + $countones(addr);
          ev    = EvNone;
          m_pos = 2'd0;
          if (code != 6'd0 && s == int'(rxb[7:4])) begin
            if (addr == m_own) begin
              if (code == CodeCallSecondary || code == CodeCallEntry) begin
                ev = EvRing;
              end else if (code == CodeCallEntryScreen) begin
                // A call soon after an opening schedules the door instead of ringing.
                if (m_opened && m_ms_open < m_window) begin
                  m_pending   = 1'b1;
                  m_remaining = m_delay;
                end else begin
                  ev = EvRingNotice;
                end
              end else if (code == CodeOpenDoor) begin
                m_opened  = 1'b1;
                m_ms_open = 16'd0;
              end
            end
            due_reports.push_back('{ev, code, addr, 8'd0, 1'b1});
          end
        end
      end
      ReqTick: begin
        if (m_opened && m_ms_open != MsSatValue) begin
          m_ms_open = m_ms_open + 16'd1;
        end
        if (m_pending) begin
          if (m_remaining <= 16'd1) begin
            m_pending   = 1'b0;
            m_remaining = 16'd0;
            owe_tx_frame(CodeOpenDoor, m_own);
          end else begin
            m_remaining = m_remaining - 16'd1;
          end
        end
      end
      ReqSend: begin
        if (lc != 6'd0) begin
          owe_tx_frame(lc, m_own);
          if (lc == CodeOpenDoor) begin
            m_opened  = 1'b1;
            m_ms_open = 16'd0;
          end
        end
      end
      default: begin
      end
    endcase
  endfunction

  task automatic check_field(input string what, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      errors++;
    end
  endtask

  // Compare every report taken from the endpoint with the oldest one owed.
  always @(posedge clk_i) begin : report_check
    report_t want;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (due_reports.size() == 0) begin
        $display("%0t: unexpected report, expected none, got ev %0d code %0h addr %0h tx %0h",
                 $time, event_res_o, frame_code_o, frame_address_o, tx_byte_o);
        errors++;
      end else begin
        want = due_reports.pop_front();
        check_field("event_res", 8'(want.ev), 8'(event_res_o));
        check_field("frame_code", 8'(want.code), 8'(frame_code_o));
        check_field("frame_address", want.addr, frame_address_o);
        check_field("tx_byte", want.tx, tx_byte_o);
        check_field("last", 8'(want.last), 8'(last_o));
      end
    end
  end

  // Receiving side: a random hold-off before each report while sink_idle is set, or a long one on demand.
  initial begin : report_sink
    int gap;
    out_stall_i = 1'b0;
    forever begin
      gap = sink_idle ? $urandom_range(0, 10) : 0;
      if (sink_hold != 0) begin
        gap       = sink_hold;
        sink_hold = 0;
      end
      if (gap > 0) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
        repeat (gap - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
    end
  end

  // Offer one request and wait until the endpoint takes it.
  task automatic send_req(input logic [1:0] kind, input logic [7:0] rxb, input logic [5:0] lc);
    int gap;
    gap = src_idle ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i   <= 1'b1;
    req_type_i   <= kind;
    rx_byte_i    <= rxb;
    local_code_i <= lc;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    react_to_request(kind, rxb, lc);
  endtask

  // Send a frame byte by byte, optionally with a corrupted checksum.
  task automatic send_frame(input logic [5:0] code, input logic [7:0] addr, input bit bad);
    logic [3:0] sum;
    int         s;
    int         k;
    s   = $countones(code) + $countones(addr);
    sum = s[3:0];
    if (bad) begin
      k   = $urandom_range(1, 15);
      sum = sum + k[3:0];
    end
    k = $urandom;
    send_req(ReqRxByte, {code[1:0], k[5:0]}, 6'($urandom_range(0, 63)));
    send_req(ReqRxByte, {addr[3:0], code[5:2]}, 6'($urandom_range(0, 63)));
    send_req(ReqRxByte, {sum, addr[7:4]}, 6'($urandom_range(0, 63)));
  endtask

  // Stop offering requests until everything owed has come out, then let the block settle.
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (due_reports.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    case (idx)
      CfgOwnAddress: m_own = val[7:0];
      CfgReopenWin:  m_window = val;
      CfgOpenDelay:  m_delay = val;
      default: begin
      end
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Ring, dropped frames, foreign address and requests that say nothing.
  task automatic test_frame_reports();
    send_frame(CodeCallSecondary, m_own, 1'b0);
    repeat (3) send_req(ReqRxByte, 8'h00, 6'h00);
    repeat (3) send_req(ReqRxByte, 8'hFF, 6'h3F);
    send_frame(CodeCallEntry, m_own + 8'd1, 1'b0);
    send_req(ReqSend, 8'hFF, 6'd0);
    send_req(ReqUnused, 8'hA5, 6'h2A);
    wait_drained();
  endtask

  // Screen-on call before an opening, inside the window and after it has run out.
  task automatic test_auto_open();
    cfg_write(CfgReopenWin, 16'd2);
    cfg_write(CfgOpenDelay, 16'd2);
    send_frame(CodeCallEntryScreen, m_own, 1'b0);
    send_frame(CodeOpenDoor, m_own, 1'b0);
    send_frame(CodeCallEntryScreen, m_own, 1'b0);
    repeat (2) send_req(ReqTick, 8'h00, 6'd0);
    send_frame(CodeCallEntryScreen, m_own, 1'b0);
    wait_drained();
  endtask

  // A local send and a tick in the middle of a frame must not disturb it.
  task automatic test_send_during_partial_frame();
    int s;
    s = $countones(CodeCallEntry) + $countones(m_own);
    send_req(ReqRxByte, {CodeCallEntry[1:0], 6'h15}, 6'd0);
    send_req(ReqSend, 8'h00, 6'd63);
    send_req(ReqTick, 8'h00, 6'd1);
    send_req(ReqRxByte, {m_own[3:0], CodeCallEntry[5:2]}, 6'd0);
    send_req(ReqRxByte, {s[3:0], m_own[7:4]}, 6'd0);
    wait_drained();
  endtask

  // The receiver holds off for a long stretch while sends keep coming, so the block fills.
  task automatic test_full_backpressure();
    int i;
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    sink_hold = 150;
    for (i = 0; i < 12; i++) begin
      send_req(ReqSend, 8'($urandom_range(0, 255)), 6'($urandom_range(1, 63)));
    end
    wait_drained();
    src_idle  = 1'b1;
    sink_idle = 1'b1;
  endtask

  // Mostly well-formed frames with random content, mixed with ticks, sends and noise.
  task automatic run_traffic(input int n);
    int         sent;
    int         pick;
    int         k;
    logic [5:0] code;
    logic [7:0] addr;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        // Realign to a frame boundary first.
        while (m_pos != 2'd0) begin
          send_req(ReqRxByte, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)));
          sent++;
        end
        k = $urandom_range(0, 9);
        if (k < 2) code = CodeOpenDoor;
        else if (k < 4) code = CodeCallEntryScreen;
        else if (k < 5) code = CodeCallSecondary;
        else if (k < 6) code = CodeCallEntry;
        else code = 6'($urandom_range(0, 63));
        addr = m_own;
        if ($urandom_range(0, 9) < 3) addr = 8'($urandom_range(0, 255));
        send_frame(code, addr, $urandom_range(0, 9) == 0);
        sent += 3;
      end else if (pick < 70) begin
        send_req(ReqTick, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)));
        sent++;
      end else if (pick < 82) begin
        k = $urandom_range(0, 9);
        if (k == 0) code = 6'd0;
        else if (k == 1) code = CodeOpenDoor;
        else code = 6'($urandom_range(1, 63));
        send_req(ReqSend, 8'($urandom_range(0, 255)), code);
        sent++;
      end else if (pick < 92) begin
        // Noise: a garbage frame or a lone byte that breaks the alignment.
        k = $urandom_range(0, 1) ? 3 : 1;
        repeat (k) send_req(ReqRxByte, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)));
        sent += k;
      end else if (pick < 97) begin
        send_req(ReqUnused, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)));
        sent++;
      end else begin
        wait_drained();
      end
    end
  endtask

  // Random traffic under the extreme settings and under a random one.
  task automatic test_random_traffic();
    cfg_write(CfgOwnAddress, 16'd0);
    cfg_write(CfgReopenWin, 16'd0);
    cfg_write(CfgOpenDelay, 16'hFFFF);
    run_traffic(30);
    wait_drained();

    cfg_write(CfgOwnAddress, 16'd255);
    cfg_write(CfgReopenWin, 16'hFFFF);
    cfg_write(CfgOpenDelay, 16'd0);
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    run_traffic(30);
    wait_drained();

    cfg_write(CfgOwnAddress, 16'($urandom_range(0, 255)));
    cfg_write(CfgReopenWin, 16'($urandom_range(3, 30)));
    cfg_write(CfgOpenDelay, 16'($urandom_range(1, 5)));
    src_idle  = 1'b1;
    sink_idle = 1'b0;
    run_traffic(12);
    sink_idle = 1'b1;
    run_traffic(12);
    wait_drained();
  endtask

  initial begin
    errors       = 0;
    cycle_count  = 0;
    src_idle     = 1'b1;
    sink_idle    = 1'b1;
    sink_hold    = 0;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    req_type_i   = ReqRxByte;
    rx_byte_i    = 8'd0;
    local_code_i = 6'd0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = CfgOwnAddress;
    cfg_data_i   = 16'd0;
    clear_mirror();
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_frame_reports();
    test_auto_open();
    test_send_during_partial_frame();
    test_full_backpressure();
    test_random_traffic();

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("** intercom_frame_receiver_autoopen: PASSED **");
    end else begin
      $display("** intercom_frame_receiver_autoopen: FAILED **");
    end
    $finish;
  end

endmodule
